@@ rtl/u8sd_pkg.sv @@
// Package for the UTF-8 stream decoder: result record, decode constants
// and the lead-length and code point assembly functions.
// No dependencies.
package u8sd_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned LenW = 3;

  localparam logic [CpW-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [7:0] MASK_CONT = 8'h3F;
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;
  localparam logic [7:0] MASK_LEAD4 = 8'h07;
  localparam logic [7:0] PFX_MASK2 = 8'hE0;
  localparam logic [7:0] PFX_MASK3 = 8'hF0;
  localparam logic [7:0] PFX_MASK4 = 8'hF8;
  localparam logic [7:0] PFX_LEAD2 = 8'hC0;
  localparam logic [7:0] PFX_LEAD3 = 8'hE0;
  localparam logic [7:0] PFX_LEAD4 = 8'hF0;

  localparam logic [LenW-1:0] LEN_BAD = 3'd0;
  localparam logic [LenW-1:0] LEN_1 = 3'd1;
  localparam logic [LenW-1:0] LEN_2 = 3'd2;
  localparam logic [LenW-1:0] LEN_3 = 3'd3;
  localparam logic [LenW-1:0] LEN_4 = 3'd4;

  typedef logic [3:0][7:0] byte4_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            is_replacement;
    logic [LenW-1:0] char_bytes;
    logic            last_of_run;
  } res_t;

  typedef struct packed {
    res_t            res;
    logic [LenW-1:0] adv;
  } step_t;

  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] len;
    if (!b[7]) len = LEN_1;
    else if ((b & PFX_MASK2) == PFX_LEAD2) len = LEN_2;
    else if ((b & PFX_MASK3) == PFX_LEAD3) len = LEN_3;
    else if ((b & PFX_MASK4) == PFX_LEAD4) len = LEN_4;
    else len = LEN_BAD;
    return len;
  endfunction

  function automatic logic [CpW-1:0] assemble(input byte4_t b, input logic [LenW-1:0] len);
    logic [CpW-1:0] cp;
    case (len)
      LEN_1: cp = {13'd0, b[0]};
      LEN_2: cp = {10'd0, b[0][4:0], b[1][5:0]};
      LEN_3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    endcase
    return cp;
  endfunction

  // One greedy decode step at byte position pos out of m valid bytes.
  function automatic step_t decode_step(input byte4_t buf_w, input logic [2:0] pos,
                                        input logic [2:0] m);
    step_t s;
    logic [7:0] b;
    logic [LenW-1:0] len;
    logic [3:0] tail;
    byte4_t win;
    b = buf_w[pos[1:0]];
    len = lead_len(b);
    tail = {1'b0, pos} + {1'b0, len};
    for (int k = 0; k < 4; k++) begin
      win[k] = buf_w[2'(pos[1:0] + 2'(k))];
    end
    s.res.last_of_run = 1'b0;
    if (len == LEN_BAD || tail > {1'b0, m}) begin
      s.res.code_point = REPL_CP;
      s.res.is_replacement = 1'b1;
      s.res.char_bytes = LEN_1;
      s.adv = LEN_1;
    end else begin
      s.res.code_point = assemble(win, len);
      s.res.is_replacement = 1'b0;
      s.res.char_bytes = len;
      s.adv = len;
    end
    return s;
  endfunction

endpackage

@@ rtl/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder, top level: input byte register, single-pass
// decode against the open-sequence state, and a three-entry result queue.
// Depends on u8sd_pkg.
//
// Usage: bytes enter on the in_ stream, one per transfer, with in_tlast on
// the last byte of a string. Decoded code points leave on the out_ stream:
// out_tdata carries the code point and the byte count, out_tuser flags a
// replacement for a bad or truncated lead, and out_tlast marks the last
// result caused by one input byte. Bytes that only extend an open sequence
// give no result.
// A byte waits in the input register and is decoded into the result queue,
// from whose head its first result leaves. One byte per cycle is sustained
// while each byte gives at most one result and the receiver is ready; a
// string end inside a sequence gives up to three results, which leave one
// per cycle to a ready receiver as the input register holds the next byte.
// The input register accepts a byte while a result waits, so a stalled
// receiver backs up one byte before in_tready falls.
// Reset empties the input register and the result queue and closes any
// open sequence.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] char_bytes
  output logic        out_tuser,  // is_replacement
  output logic        out_tlast   // last_of_run
);
  import u8sd_pkg::*;

  logic            in_v_r, in_v_nxt;
  logic [7:0]      in_byte_r;
  logic            in_eos_r;

  logic [7:0]      held_r [3];
  logic [1:0]      hc_r, hc_nxt;
  logic [LenW-1:0] exp_r, exp_nxt;

  res_t            q_r [3];
  logic [1:0]      q_cnt_r, q_cnt_nxt;

  logic            pop, drain_ok, dec_fire;
  byte4_t          buf_w;
  logic [2:0]      m;
  logic [LenW-1:0] len0;
  step_t           s0, s1, s2;
  logic [2:0]      pos1, pos2;
  logic            v1, v2;
  res_t            r [3];
  logic [1:0]      n;
  logic            hold_byte;

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign pop = out_tvalid && out_tready;
  assign drain_ok = (q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && out_tready);
  assign dec_fire = in_v_r && drain_ok;
  assign in_tready = !in_v_r || dec_fire;

  assign out_tdata = {q_r[0].char_bytes, q_r[0].code_point};
  assign out_tuser = q_r[0].is_replacement;
  assign out_tlast = q_r[0].last_of_run;

  // Byte window: held bytes first, the new byte at the held count.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 2'(i) < hc_r) buf_w[i] = held_r[i];
      else if (3'(i) == {1'b0, hc_r}) buf_w[i] = in_byte_r;
      else buf_w[i] = 8'd0;
    end
    m = {1'b0, hc_r} + 3'd1;
  end

  // Flush decode at string end: at most three greedy steps.
  always_comb begin
    s0 = decode_step(buf_w, 3'd0, m);
    pos1 = s0.adv;
    v1 = pos1 < m;
    s1 = decode_step(buf_w, pos1, m);
    pos2 = pos1 + s1.adv;
    v2 = v1 && (pos2 < m);
    s2 = decode_step(buf_w, pos2, m);
  end

  always_comb begin
    len0 = lead_len(in_byte_r);
    hold_byte = 1'b0;
    hc_nxt = hc_r;
    exp_nxt = exp_r;
    r[0] = s0.res;
    r[1] = s1.res;
    r[2] = s2.res;
    n = 2'd0;
    if (in_eos_r) begin
      n = 2'd1 + {1'b0, v1} + {1'b0, v2};
      hc_nxt = 2'd0;
      exp_nxt = LEN_BAD;
    end else if (hc_r == 2'd0) begin
      if (len0 == LEN_BAD) begin
        n = 2'd1;
        r[0].code_point = REPL_CP;
        r[0].is_replacement = 1'b1;
        r[0].char_bytes = LEN_1;
      end else if (len0 == LEN_1) begin
        n = 2'd1;
        r[0].code_point = {13'd0, in_byte_r};
        r[0].is_replacement = 1'b0;
        r[0].char_bytes = LEN_1;
      end else begin
        hold_byte = 1'b1;
        hc_nxt = 2'd1;
        exp_nxt = len0;
      end
    end else if (m >= exp_r) begin
      n = 2'd1;
      r[0].code_point = assemble(buf_w, exp_r);
      r[0].is_replacement = 1'b0;
      r[0].char_bytes = exp_r;
      hc_nxt = 2'd0;
      exp_nxt = LEN_BAD;
    end else begin
      hold_byte = 1'b1;
      hc_nxt = hc_r + 2'd1;
    end
    r[0].last_of_run = (n == 2'd1);
    r[1].last_of_run = (n == 2'd2);
    r[2].last_of_run = (n == 2'd3);
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (dec_fire) in_v_nxt = 1'b0;
    if (in_tvalid && in_tready) in_v_nxt = 1'b1;
    q_cnt_nxt = q_cnt_r;
    if (dec_fire) q_cnt_nxt = n;
    else if (pop) q_cnt_nxt = q_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      hc_r <= 2'd0;
      exp_r <= LEN_BAD;
      q_cnt_r <= 2'd0;
    end else begin
      in_v_r <= in_v_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (dec_fire) begin
        hc_r <= hc_nxt;
        exp_r <= exp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r <= in_tlast;
    end
    if (dec_fire && hold_byte && hc_r != 2'd3) begin
      held_r[hc_r] <= in_byte_r;
    end
    if (dec_fire) begin
      for (int i = 0; i < 3; i++) q_r[i] <= r[i];
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

endmodule

@@ dv/utf8_stream_decoder_core_test.sv @@
// Self-checking testbench for utf8_stream_decoder_core: streams byte strings into the
// decoder and checks every decoded code point against an in-bench predictor.
// Depends on u8sd_pkg and the decoder RTL.
module utf8_stream_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } text_byte_t;

  // Tracks the open sequence and holds the code points still owed by the decoder.
  class code_point_checker;
    res_t        pending[$];
    logic [7:0]  held[3];
    int unsigned held_n;
    int unsigned seq_len;
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned decoded;
    int unsigned replaced;
    int unsigned strings;

    function new();
      held_n = 0;
      seq_len = 0;
      errors = 0;
      bytes_in = 0;
      decoded = 0;
      replaced = 0;
      strings = 0;
    endfunction

    function int unsigned lead_length(logic [7:0] b);
      if (!b[7]) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
    endfunction

    function logic [20:0] code_point_of(logic [7:0] s[4], int unsigned pos, int unsigned len);
      case (len)
        1: return {13'd0, s[pos]};
        2: return {10'd0, s[pos][4:0], s[pos+1][5:0]};
        3: return {5'd0, s[pos][3:0], s[pos+1][5:0], s[pos+2][5:0]};
        default: return {s[pos][2:0], s[pos+1][5:0], s[pos+2][5:0], s[pos+3][5:0]};
      endcase
    endfunction

    function res_t make_result(logic [20:0] cp, logic repl, int unsigned n);
      res_t r;
      r.code_point = cp;
      r.is_replacement = repl;
      r.char_bytes = n[2:0];
      r.last_of_run = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [7:0] data, logic eos);
      logic [7:0]  s[4];
      res_t        run[$];
      res_t        r;
      int unsigned m;
      int unsigned pos;
      int unsigned len;
      bytes_in++;
      for (int k = 0; k < 4; k++) s[k] = 8'h00;
      for (int k = 0; k < held_n; k++) s[k] = held[k];
      s[held_n] = data;
      m = held_n + 1;
      if (!eos) begin
        if (held_n == 0) begin
          len = lead_length(data);
          if (len == 0) run = {run, make_result(REPL_CP, 1'b1, 1)};
          else if (len == 1) run = {run, make_result({13'd0, data}, 1'b0, 1)};
          else begin
            held[0] = data;
            held_n = 1;
            seq_len = len;
          end
        end else if (m >= seq_len) begin
          run = {run, make_result(code_point_of(s, 0, seq_len), 1'b0, seq_len)};
          held_n = 0;
          seq_len = 0;
        end else begin
          held[held_n] = data;
          held_n++;
        end
      end else begin
        // The string ended: decode whatever is buffered greedily, a lead that
        // does not fit in the remaining bytes becomes a replacement.
        pos = 0;
        while (pos < m && run.size() < 3) begin
          len = lead_length(s[pos]);
          if (len == 0 || pos + len > m) begin
            run = {run, make_result(REPL_CP, 1'b1, 1)};
            pos++;
          end else begin
            run = {run, make_result(code_point_of(s, pos, len), 1'b0, len)};
            pos += len;
          end
        end
        held_n = 0;
        seq_len = 0;
        strings++;
      end
      foreach (run[k]) begin
        r = run[k];
        r.last_of_run = (k == run.size() - 1);
        pending = {pending, r};
      end
    endfunction

    function void check_code_point(logic [20:0] cp, logic repl, logic [2:0] n, logic last);
      res_t got;
      res_t want;
      got.code_point = cp;
      got.is_replacement = repl;
      got.char_bytes = n;
      got.last_of_run = last;
      decoded++;
      if (repl) replaced++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected code point %06h repl %0d bytes %0d last %0d",
                 $time, cp, repl, n, last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected cp %06h repl %0d bytes %0d last %0d", $time,
                 want.code_point, want.is_replacement, want.char_bytes, want.last_of_run);
        $display("%0t:          actual   cp %06h repl %0d bytes %0d last %0d", $time,
                 got.code_point, got.is_replacement, got.char_bytes, got.last_of_run);
      end
    endfunction
  endclass

  // Directed strings, bit 8 set on the last byte of a string.
  localparam logic [8:0] DIRECTED [24] = '{
    9'h000, 9'h17F,                          // ASCII extremes, together as one string
    9'h0C2, 9'h0A9,                          // two-byte character
    9'h0EF, 9'h0BF, 9'h0BD,                  // a genuine U+FFFD in the text
    9'h0F0, 9'h09F, 9'h098, 9'h080,          // four-byte character
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,          // largest lead, largest code point
    9'h080, 9'h0FF,                          // stray continuation and invalid lead
    9'h0F4, 9'h041, 9'h142,                  // truncated lead, then two ASCII bytes
    9'h0F0, 9'h0C3, 9'h1A9,                  // truncated lead, then a two-byte char
    9'h1C3                                   // string ends on a lone lead
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [20:0] code_point, [23:21] char_bytes
  logic        out_tuser;          // is_replacement
  logic        out_tlast;          // last_of_run

  code_point_checker sb = new();
  text_byte_t        text[$];
  int unsigned       stall_left = 0;
  int unsigned       stall_mode = 0;

  utf8_stream_decoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // The receiver switches between always ready, random, sparse and periodic stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_code_point(out_tdata[20:0], out_tuser, out_tdata[23:21], out_tlast);
    end
  end

  task automatic add_byte(input logic [7:0] data, input logic eos);
    text_byte_t t;
    t.data = data;
    t.eos = eos;
    text = {text, t};
  endtask

  // Mostly well-formed characters with random payload, some cut short, some noise.
  task automatic build_random_text(input int unsigned count);
    int unsigned kind;
    int unsigned len;
    int unsigned conts;
    logic [7:0]  lead;
    logic        eos;
    while (text.size() < count) begin
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
        add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else begin
        len = (kind == 7) ? $urandom_range(2, 4) : $urandom_range(1, 4);
        case (len)
          1: lead = 8'($urandom_range(0, 127));
          2: lead = 8'hC0 | 8'($urandom_range(0, 31));
          3: lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        conts = (kind == 7) ? $urandom_range(0, len - 2) : len - 1;
        eos = (kind == 7) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        if (conts == 0) begin
          add_byte(lead, eos);
        end else begin
          add_byte(lead, 1'b0);
          for (int k = 1; k < conts; k++) add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
          add_byte(8'h80 | 8'($urandom_range(0, 63)), eos);
        end
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] data, input logic eos);
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(data, eos);
    @(negedge clk);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    foreach (DIRECTED[i]) add_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    build_random_text(380);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    burst_left = 0;
    foreach (text[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      send_byte(text[i].data, text[i].eos);
      burst_left--;
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d terminated strings under bursty input and stalls;",
             sb.bytes_in, sb.strings);
    $display("checked %0d code points, %0d of them replacements.", sb.decoded, sb.replaced);
    if (sb.errors == 0) begin
      $display("PASS utf8_stream_decoder_core");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("FAIL utf8_stream_decoder_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d code points still owed.", sb.pending.size());
    $display("FAIL utf8_stream_decoder_core");
    $finish;
  end

endmodule

@@ utf8_stream_decoder_core.f @@
rtl/u8sd_pkg.sv
rtl/utf8_stream_decoder_core.sv
dv/utf8_stream_decoder_core_test.sv
